// File: hw/rtl/fip_pkg.sv
// ----------------------------------------------------------------------------
// fip_pkg
// Shared types and constants for the double integer-power block.
// ----------------------------------------------------------------------------
package fip_pkg;

  localparam logic [63:0] DBL_ONE      = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] DBL_ZERO     = 64'h0000_0000_0000_0000;
  localparam logic [63:0] DBL_INF      = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] DBL_DFLT_NAN = 64'hFFF8_0000_0000_0000;
  localparam logic [62:0] DBL_TINY_MAG = 63'h3DDB_7CDF_D9D7_BDBB;  // 1e-10
  localparam logic [63:0] DBL_QUIET    = 64'h0008_0000_0000_0000;

  typedef enum logic [1:0] {
    OP_MUL = 2'b01,
    OP_DIV = 2'b10
  } fpu_op_t;

  typedef struct packed {
    logic    start;
    fpu_op_t op;
  } fpu_req_t;

  function automatic logic is_nan(input logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

  function automatic logic is_inf(input logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] == 52'd0);
  endfunction

  function automatic logic is_zero(input logic [63:0] x);
    return x[62:0] == 63'd0;
  endfunction

endpackage

// File: hw/rtl/fip_fpu.sv
// ----------------------------------------------------------------------------
// fip_fpu
// Iterative double multiply / reciprocal with round to nearest even.
// ----------------------------------------------------------------------------
module fip_fpu (
  input  logic              clk,
  input  logic              rst_n,
  input  fip_pkg::fpu_req_t req_i,
  input  logic [63:0]       a_i,
  input  logic [63:0]       b_i,
  output logic              done_o,
  output logic [63:0]       res_o
);
  import fip_pkg::*;

  typedef enum logic [7:0] {
    F_IDLE   = 8'b0000_0001,
    F_MUL    = 8'b0000_0010,
    F_DNORM  = 8'b0000_0100,
    F_DIV    = 8'b0000_1000,
    F_NORM   = 8'b0001_0000,
    F_DENORM = 8'b0010_0000,
    F_ROUND  = 8'b0100_0000,
    F_DONE   = 8'b1000_0000
  } fstate_t;

  fstate_t             state_r, state_nxt;
  logic [52:0]         ma_r, ma_nxt, mb_r, mb_nxt;
  logic                sign_r, sign_nxt;
  logic signed [12:0]  exp_r, exp_nxt;
  logic [105:0]        p_r, p_nxt;
  logic [53:0]         pp_r, pp_nxt;
  logic [53:0]         rem_r, rem_nxt;
  logic [5:0]          cnt_r, cnt_nxt;
  logic                stk_r, stk_nxt;
  logic [63:0]         res_r, res_nxt;

  logic [52:0]         ma_in, mb_in;
  logic signed [12:0]  ea_in, eb_in;
  logic                sa, sb;
  logic [26:0]         mx, my;
  logic [105:0]        pp_sh;
  logic                ge;
  logic [53:0]         rdiff;
  logic [52:0]         m53;
  logic                rnd_up, sticky;
  logic [53:0]         m54;
  logic [52:0]         mant;
  logic signed [12:0]  e_rnd;

  assign sa    = a_i[63];
  assign sb    = b_i[63];
  assign ma_in = {a_i[62:52] != 11'd0, a_i[51:0]};
  assign mb_in = {b_i[62:52] != 11'd0, b_i[51:0]};
  assign ea_in = (a_i[62:52] == 11'd0) ? 13'sd1 : $signed({2'b00, a_i[62:52]});
  assign eb_in = (b_i[62:52] == 11'd0) ? 13'sd1 : $signed({2'b00, b_i[62:52]});

  // 27x27 partial products, one per cycle
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    begin mx = ma_r[26:0];          my = mb_r[26:0];          end
      2'd1:    begin mx = ma_r[26:0];          my = {1'b0, mb_r[52:27]}; end
      2'd2:    begin mx = {1'b0, ma_r[52:27]}; my = mb_r[26:0];          end
      default: begin mx = {1'b0, ma_r[52:27]}; my = {1'b0, mb_r[52:27]}; end
    endcase
    case (cnt_r[2:0])
      3'd2, 3'd3: pp_sh = {52'd0, pp_r} << 27;
      3'd4:       pp_sh = {52'd0, pp_r} << 54;
      default:    pp_sh = {52'd0, pp_r};
    endcase
  end

  assign ge    = rem_r >= {1'b0, mb_r};
  assign rdiff = ge ? (rem_r - {1'b0, mb_r}) : rem_r;

  assign m53    = p_r[105:53];
  assign sticky = (p_r[51:0] != 52'd0) | stk_r;
  assign rnd_up = p_r[52] & (sticky | m53[0]);
  assign m54    = {1'b0, m53} + {53'd0, rnd_up};
  assign mant   = m54[53] ? m54[53:1] : m54[52:0];
  assign e_rnd  = exp_r + $signed({12'd0, m54[53]});

  always_comb begin
    state_nxt = state_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    sign_nxt  = sign_r;
    exp_nxt   = exp_r;
    p_nxt     = p_r;
    pp_nxt    = pp_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    stk_nxt   = stk_r;
    res_nxt   = res_r;
    case (state_r)
      F_IDLE: begin
        if (req_i.start) begin
          p_nxt   = '0;
          cnt_nxt = '0;
          stk_nxt = 1'b0;
          rem_nxt = 54'd1 << 52;
          if (req_i.op == OP_MUL) begin
            sign_nxt = sa ^ sb;
            if (is_nan(a_i)) begin
              res_nxt = a_i | DBL_QUIET;  state_nxt = F_DONE;
            end else if (is_nan(b_i)) begin
              res_nxt = b_i | DBL_QUIET;  state_nxt = F_DONE;
            end else if ((is_inf(a_i) && is_zero(b_i)) || (is_zero(a_i) && is_inf(b_i))) begin
              res_nxt = DBL_DFLT_NAN;     state_nxt = F_DONE;
            end else if (is_inf(a_i) || is_inf(b_i)) begin
              res_nxt = {sa ^ sb, DBL_INF[62:0]};  state_nxt = F_DONE;
            end else if (is_zero(a_i) || is_zero(b_i)) begin
              res_nxt = {sa ^ sb, 63'd0};  state_nxt = F_DONE;
            end else begin
              ma_nxt    = ma_in;
              mb_nxt    = mb_in;
              exp_nxt   = ea_in + eb_in - 13'sd1022;
              state_nxt = F_MUL;
            end
          end else begin
            sign_nxt = sb;
            if (is_nan(b_i)) begin
              res_nxt = b_i | DBL_QUIET;  state_nxt = F_DONE;
            end else if (is_inf(b_i)) begin
              res_nxt = {sb, 63'd0};      state_nxt = F_DONE;
            end else if (is_zero(b_i)) begin
              res_nxt = {sb, DBL_INF[62:0]};  state_nxt = F_DONE;
            end else begin
              mb_nxt    = mb_in;
              exp_nxt   = 13'sd2046 - eb_in;
              state_nxt = F_DNORM;
            end
          end
        end
      end
      F_MUL: begin
        if (cnt_r[2:0] != 3'd4) pp_nxt = 54'(mx * my);
        if (cnt_r[2:0] != 3'd0) p_nxt = p_r + pp_sh;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r[2:0] == 3'd4) state_nxt = F_NORM;
      end
      F_DNORM: begin
        // bring a subnormal divisor up to 1.x
        if (!mb_r[52]) begin
          mb_nxt  = {mb_r[51:0], 1'b0};
          exp_nxt = exp_r + 13'sd1;
        end else begin
          state_nxt = F_DIV;
        end
      end
      F_DIV: begin
        rem_nxt = {rdiff[52:0], 1'b0};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd54) begin
          p_nxt     = {p_r[53:0], ge, 50'd0, rdiff != 54'd0};
          state_nxt = F_NORM;
        end else begin
          p_nxt = {p_r[104:0], ge};
        end
      end
      F_NORM: begin
        if (!p_r[105]) begin
          p_nxt   = {p_r[104:0], 1'b0};
          exp_nxt = exp_r - 13'sd1;
        end else if (exp_r < 13'sd1) begin
          state_nxt = F_DENORM;
        end else begin
          state_nxt = F_ROUND;
        end
      end
      F_DENORM: begin
        if (exp_r < -13'sd120) begin
          // far below the subnormal range: only sticky survives
          p_nxt     = '0;
          stk_nxt   = 1'b1;
          exp_nxt   = 13'sd1;
          state_nxt = F_ROUND;
        end else if (exp_r < 13'sd1) begin
          stk_nxt = stk_r | p_r[0];
          p_nxt   = {1'b0, p_r[105:1]};
          exp_nxt = exp_r + 13'sd1;
        end else begin
          state_nxt = F_ROUND;
        end
      end
      F_ROUND: begin
        if (e_rnd >= 13'sd2047) res_nxt = {sign_r, DBL_INF[62:0]};
        else res_nxt = {sign_r, mant[52] ? e_rnd[10:0] : 11'd0, mant[51:0]};
        state_nxt = F_DONE;
      end
      F_DONE:  state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    sign_r <= sign_nxt;
    exp_r  <= exp_nxt;
    p_r    <= p_nxt;
    pp_r   <= pp_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    stk_r  <= stk_nxt;
    res_r  <= res_nxt;
  end

  assign done_o = (state_r == F_DONE);
  assign res_o  = res_r;

endmodule

// File: hw/rtl/float_integer_power.sv
// ----------------------------------------------------------------------------
// float_integer_power
// Double base raised to a signed integer power by square-and-multiply.
// ----------------------------------------------------------------------------
// channel  direction  ports
// in       input      in_valid, in_ready, in_base_value, in_exponent
// out      output     out_valid, out_ready, out_power_value
//
// One item at a time. Each multiply runs through the shared 27x27
// multiplier unit and takes longer when the product is subnormal, shifting
// one bit at a time; there are up to 2*EXP_BITS-3 multiplies. A negative
// exponent adds a reciprocal (one quotient bit per cycle).
// in_ready is high only when idle; the result holds in out_power_value until
// transferred. Synchronous active-low reset returns the block to idle.
// ----------------------------------------------------------------------------
module float_integer_power #(
  parameter int EXP_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_base_value,
  input  logic signed [63:0] in_exponent,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_power_value
);
  import fip_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOOP = 6'b000010,
    S_WACC = 6'b000100,
    S_WSQ  = 6'b001000,
    S_WREC = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [EXP_BITS-1:0] mag_r, mag_nxt;
  logic                neg_r, neg_nxt;
  logic [63:0]         acc_r, acc_nxt, sq_r, sq_nxt, res_r, res_nxt;

  logic [EXP_BITS-1:0] e_in, mag_in;
  logic                neg_in;
  fpu_req_t            req;
  logic [63:0]         op_a, op_b, fpu_res;
  logic                fpu_done;

  assign e_in   = in_exponent[EXP_BITS-1:0];
  assign neg_in = e_in[EXP_BITS-1];
  assign mag_in = neg_in ? (~e_in + 1'b1) : e_in;

  fip_fpu u_fpu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req_i  (req),
    .a_i    (op_a),
    .b_i    (op_b),
    .done_o (fpu_done),
    .res_o  (fpu_res)
  );

  always_comb begin
    state_nxt = state_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    sq_nxt    = sq_r;
    res_nxt   = res_r;
    req.start = 1'b0;
    req.op    = OP_MUL;
    op_a      = sq_r;
    op_b      = sq_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mag_nxt = mag_in;
          neg_nxt = neg_in;
          acc_nxt = DBL_ONE;
          sq_nxt  = in_base_value;
          if (in_base_value[62:0] < DBL_TINY_MAG) begin
            res_nxt   = (mag_in == '0) ? DBL_ONE : DBL_ZERO;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_LOOP;
          end
        end
      end
      S_LOOP: begin
        if (mag_r == '0) begin
          if (!neg_r) begin
            res_nxt   = acc_r;
            state_nxt = S_OUT;
          end else begin
            req.start = 1'b1;
            req.op    = OP_DIV;
            op_b      = acc_r;
            state_nxt = S_WREC;
          end
        end else if (mag_r[0]) begin
          req.start = 1'b1;
          op_a      = acc_r;
          state_nxt = S_WACC;
        end else begin
          req.start = 1'b1;
          state_nxt = S_WSQ;
        end
      end
      S_WACC: begin
        if (fpu_done) begin
          acc_nxt   = fpu_res;
          // bit consumed; after the last set bit the loop ends with no square
          mag_nxt   = {mag_r[EXP_BITS-1:1], 1'b0};
          state_nxt = S_LOOP;
        end
      end
      S_WSQ: begin
        if (fpu_done) begin
          sq_nxt    = fpu_res;
          mag_nxt   = mag_r >> 1;
          state_nxt = S_LOOP;
        end
      end
      S_WREC: begin
        if (fpu_done) begin
          res_nxt   = fpu_res;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    acc_r <= acc_nxt;
    sq_r  <= sq_nxt;
    res_r <= res_nxt;
  end

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = (state_r == S_OUT);
  assign out_power_value = res_r;

endmodule

// File: test/tb_float_integer_power.sv
// ----------------------------------------------------------------------------
// tb_float_integer_power
// Checks the double integer-power block against a square-and-multiply
// predictor built on IEEE double reals. A directed set of corner cases is
// followed by random traffic with random idle on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_float_integer_power;
  import fip_pkg::*;

  localparam int  N_RANDOM    = 1630;
  localparam int  CYCLE_LIMIT = 20_000_000;

  typedef struct {
    logic [63:0]        base;
    logic signed [63:0] expo;
    logic               drain;
  } power_req_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [63:0]        in_base_value = '0;
  logic signed [63:0] in_exponent = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [63:0]        out_power_value;

  power_req_t  req_q[$];
  logic [63:0] power_q[$];
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  int          errors = 0;
  int          sent = 0;
  int          got = 0;
  int          send_gap = 0;
  int          recv_stall = 0;
  longint      cycles = 0;

  float_integer_power u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_base_value(in_base_value), .in_exponent(in_exponent),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_power_value(out_power_value)
  );

  always #1 clk = ~clk;

  function automatic logic [63:0] int_power(logic [63:0] b, logic signed [63:0] e);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] acc_bits;
    real         acc;
    real         sq;
    neg = e[63];
    mag = neg ? 64'(-e) : 64'(e);   // most negative keeps magnitude 2^63
    if (b[62:0] < DBL_TINY_MAG) return (mag == 0) ? DBL_ONE : DBL_ZERO;
    acc = 1.0;
    sq  = $bitstoreal(b);
    while (mag != 0) begin
      if (mag[0]) acc = acc * sq;
      sq  = sq * sq;
      mag = mag >> 1;
    end
    acc_bits = $realtobits(acc);
    if (!neg) return acc_bits;
    if (acc_bits[62:0] == 63'd0) return {acc_bits[63], DBL_INF[62:0]};
    return $realtobits(1.0 / acc);
  endfunction

  function automatic int idle_draw(int n);
    // every 200 transfers, a run of 50 without idle
    return ((n % 200) < 50) ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic logic [63:0] rand_base();
    logic [63:0] b;
    b = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: b[62:52] = 11'h3FF - 11'($urandom_range(0, 1));  // near one
      4:          b[62:52] = 11'h3FF + 11'($urandom_range(0, 12)) - 11'd6;
      5:          b[62:52] = 11'd0;                                 // subnormal
      6:          b[62:52] = DBL_TINY_MAG[62:52] + 11'($urandom_range(0, 1)) - 11'd1;
      7:          b[62:52] = 11'h7FF;                               // inf / NaN
      default: ;
    endcase
    return b;
  endfunction

  function automatic logic signed [63:0] rand_expo();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 64'($signed($urandom_range(0, 80)) - 40);
      6:                return 64'($signed($urandom_range(0, 4000)) - 2000);
      default:          return {$urandom, $urandom};
    endcase
  endfunction

  task automatic add_req(logic [63:0] b, logic signed [63:0] e, logic d = 1'b0);
    power_req_t r;
    r.base  = b;
    r.expo  = e;
    r.drain = d;
    req_q.push_back(r);
  endtask

  // sender
  always @(negedge clk) begin
    logic       drive;
    power_req_t r;
    drive = in_valid && !in_fire;
    if (rst_n && !drive) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (req_q.size() > 0 && !(req_q[0].drain && power_q.size() > 0)) begin
        r = req_q.pop_front();
        in_base_value <= r.base;
        in_exponent   <= r.expo;
        send_gap      <= idle_draw(sent);
        sent          <= sent + 1;
        drive = 1'b1;
      end
    end
    in_valid <= drive;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    int st;
    st = out_fire ? idle_draw(got) : recv_stall;
    if (rst_n && st == 0) begin
      out_ready <= 1'b1;
      recv_stall <= 0;
    end else begin
      out_ready <= 1'b0;
      recv_stall <= (st > 0) ? st - 1 : 0;
    end
  end

  // predictor and result check
  always @(posedge clk) begin
    logic [63:0] want;
    in_fire  <= in_valid && in_ready;
    out_fire <= out_valid && out_ready;
    cycles   <= cycles + 1;
    if (rst_n && in_valid && in_ready)
      power_q.push_back(int_power(in_base_value, in_exponent));
    if (rst_n && out_valid && out_ready) begin
      got <= got + 1;
      if (power_q.size() == 0) begin
        $error("power_value: unexpected transfer, actual %h", out_power_value);
        errors <= errors + 1;
      end else begin
        want = power_q.pop_front();
        if (out_power_value !== want) begin
          $error("power_value: expected %h actual %h", want, out_power_value);
          errors <= errors + 1;
        end
      end
    end
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    // directed corners
    add_req(DBL_ONE, 64'sd0);
    add_req(64'h4000_0000_0000_0000, 64'sd10);
    add_req(64'h4000_0000_0000_0000, -64'sd3);
    add_req(64'hC000_0000_0000_0000, 64'sd3);
    add_req(64'hC000_0000_0000_0000, -64'sd5);
    add_req(DBL_ZERO, 64'sd0);
    add_req(64'h8000_0000_0000_0000, 64'sd5);
    add_req(DBL_ZERO, -64'sd1);
    add_req({1'b0, DBL_TINY_MAG}, 64'sd2);
    add_req({1'b1, DBL_TINY_MAG - 63'd1}, -64'sd2);
    add_req(DBL_DFLT_NAN, 64'sd0);
    add_req(DBL_DFLT_NAN, 64'sd7);
    add_req(64'h7FF0_0000_0000_0001, -64'sd3);
    add_req(DBL_INF, -64'sd1);
    add_req({1'b1, DBL_INF[62:0]}, 64'sd3);
    add_req(64'h3FF0_0000_0000_0001, 64'h8000_0000_0000_0000);
    add_req(64'hBFF0_0000_0000_0000, 64'h8000_0000_0000_0000);
    add_req(64'h3FEF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF);
    add_req(64'h4024_0000_0000_0000, 64'sd400);
    add_req(64'h4024_0000_0000_0000, -64'sd400);
    add_req(64'h3E00_0000_0000_0000, 64'sd40);   // last product underflows below the subnormal range
    add_req(64'h0000_0000_0000_0001, 64'sd1);
    add_req(64'hFFFF_FFFF_FFFF_FFFF, 64'sd1);
    add_req(64'h3FF8_0000_0000_0000, -64'sd1, 1'b1);
    for (int i = 0; i < N_RANDOM; i++)
      add_req(rand_base(), rand_expo(), (i % 400) == 399);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // sample at the clock edge so a queue pop and its valid settle together
    forever begin
      @(posedge clk);
      if (req_q.size() == 0 && !in_valid && power_q.size() == 0) break;
    end
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: float_integer_power.f
hw/rtl/fip_pkg.sv
hw/rtl/fip_fpu.sv
hw/rtl/float_integer_power.sv
test/tb_float_integer_power.sv
